// ----- rtl/gwch_pkg.sv -----
// ============================================================================
// gwch_pkg
// Shared types and constants for the gift-wrapping convex hull block.
// ============================================================================
package gwch_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int POINT_W = 3 * COORD_W;

    // x in the lowest bits, matching the stream word layout
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_RD,
        ST_START_SCAN,
        ST_ROUND_RD,
        ST_CAND0,
        ST_MUL1,
        ST_MUL2,
        ST_CMP,
        ST_EMIT,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } alu_ctrl_t;

    typedef struct packed {
        logic left;
        logic cand_is_cur;
    } alu_stat_t;

endpackage

// ----- rtl/gwch_store.sv -----
// ============================================================================
// gwch_store
// Point memory: one write port, one read port with registered read data.
// ============================================================================
module gwch_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  gwch_pkg::point_t wdata,
    input  logic [AW-1:0]   raddr,
    output gwch_pkg::point_t rdata
);

    gwch_pkg::point_t mem [DEPTH];
    gwch_pkg::point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gwch_alu.sv -----
// ============================================================================
// gwch_alu
// Shared cross-product unit: one signed multiplier used in two passes.
// ============================================================================
module gwch_alu (
    input  logic                clk,
    input  gwch_pkg::alu_ctrl_t ctrl,
    input  gwch_pkg::point_t    cur,
    input  gwch_pkg::point_t    cand,
    input  gwch_pkg::point_t    pnt,
    output gwch_pkg::alu_stat_t stat
);

    logic signed [gwch_pkg::DIFF_W-1:0] op_a;
    logic signed [gwch_pkg::DIFF_W-1:0] op_b;
    logic signed [gwch_pkg::PROD_W-1:0] prod;
    logic signed [gwch_pkg::PROD_W-1:0] prod_a_reg;
    logic signed [gwch_pkg::PROD_W-1:0] prod_b_reg;

    // first pass: (cand.x - cur.x) * (p.y - cur.y)
    // second pass: (p.x - cur.x) * (cand.y - cur.y)
    always_comb
    begin
        if (ctrl.load_a)
        begin
            op_a = $signed({cand.x[gwch_pkg::COORD_W-1], cand.x})
                 - $signed({cur.x[gwch_pkg::COORD_W-1], cur.x});
            op_b = $signed({pnt.y[gwch_pkg::COORD_W-1], pnt.y})
                 - $signed({cur.y[gwch_pkg::COORD_W-1], cur.y});
        end
        else
        begin
            op_a = $signed({pnt.x[gwch_pkg::COORD_W-1], pnt.x})
                 - $signed({cur.x[gwch_pkg::COORD_W-1], cur.x});
            op_b = $signed({cand.y[gwch_pkg::COORD_W-1], cand.y})
                 - $signed({cur.y[gwch_pkg::COORD_W-1], cur.y});
        end
        prod = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            prod_a_reg <= prod;
        end
        if (ctrl.load_b)
        begin
            prod_b_reg <= prod;
        end
    end

    // cross product > 0 is the same as first product > second product
    assign stat.left        = prod_a_reg > prod_b_reg;
    assign stat.cand_is_cur = (cand == cur);

endmodule

// ----- rtl/gift_wrap_convex_hull.sv -----
// ============================================================================
// gift_wrap_convex_hull
// Gift-wrapping convex hull in the xy plane over a stored point set.
//
//  channel | dir | tdata [47:0]          | tlast      | tuser
//  --------+-----+-----------------------+------------+--------------
//  s_      | in  | point_x, _y, _z       | last_point | -
//  m_      | out | hull_x, _y, _z        | hull_end   | hull_aborted
//
// Points are stored as they are accepted. After the last point of a set, the
// start search reads each stored point in turn, and each hull round reads
// every point, with the single shared multiplier doing two passes per point
// plus a compare; the round's word is loaded at the end of the round, then
// the closing word is loaded. Input is not ready from the last point until
// the closing word is loaded. Reset clears all control state; the point
// memory needs no clearing. A stalled output holds the sequencer in its emit
// or close state.
// ============================================================================
module gift_wrap_convex_hull #(
    parameter int MAX_POINTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x, point_y, point_z
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // hull_x, hull_y, hull_z
    output logic        m_tlast,   // hull_end
    output logic        m_tuser    // hull_aborted
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int RND_W = $clog2(MAX_POINTS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_POINTS);
    localparam logic [RND_W-1:0] ROUNDS_MAX = RND_W'(MAX_POINTS + 1);

    gwch_pkg::state_t    state_reg, state_next;
    gwch_pkg::point_t    start_reg, start_next;
    gwch_pkg::point_t    cur_reg, cur_next;
    gwch_pkg::point_t    cand_reg, cand_next;
    gwch_pkg::point_t    rd_pt;
    gwch_pkg::point_t    out_pt_reg, out_pt_next;
    gwch_pkg::alu_ctrl_t alu_ctrl;
    gwch_pkg::alu_stat_t alu_stat;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] j_reg, j_next, j_inc;
    logic [RND_W-1:0] round_reg, round_next;
    logic             dropped_reg, dropped_next;
    logic             closed_reg, closed_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    logic             out_user_reg, out_user_next;
    logic [IDX_W-1:0] rd_addr;
    logic             store_we;
    logic             in_accept;
    logic             out_free;
    logic             more_points;
    logic             take_start;
    logic             cand_is_start;

    gwch_store #(
        .DEPTH (MAX_POINTS),
        .AW    (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (gwch_pkg::point_t'(s_tdata)),
        .raddr (rd_addr),
        .rdata (rd_pt)
    );

    gwch_alu u_alu (
        .clk  (clk),
        .ctrl (alu_ctrl),
        .cur  (cur_reg),
        .cand (cand_reg),
        .pnt  (rd_pt),
        .stat (alu_stat)
    );

    assign s_tready      = (state_reg == gwch_pkg::ST_IDLE);
    assign in_accept     = s_tvalid && s_tready;
    assign out_free      = !out_valid_reg || m_tready;
    assign j_inc         = j_reg + CNT_W'(1);
    assign more_points   = (j_inc < count_reg);
    assign take_start    = (j_reg == '0) || ($signed(rd_pt.x) < $signed(start_reg.x));
    assign cand_is_start = (cand_reg == start_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gwch_pkg::ST_IDLE:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = gwch_pkg::ST_START_RD;
                end
            end
            gwch_pkg::ST_START_RD:
            begin
                state_next = gwch_pkg::ST_START_SCAN;
            end
            gwch_pkg::ST_START_SCAN:
            begin
                if (!more_points)
                begin
                    state_next = gwch_pkg::ST_ROUND_RD;
                end
            end
            gwch_pkg::ST_ROUND_RD:
            begin
                state_next = gwch_pkg::ST_CAND0;
            end
            gwch_pkg::ST_CAND0:
            begin
                if (CNT_W'(1) < count_reg)
                begin
                    state_next = gwch_pkg::ST_MUL1;
                end
                else
                begin
                    state_next = gwch_pkg::ST_EMIT;
                end
            end
            gwch_pkg::ST_MUL1:
            begin
                state_next = gwch_pkg::ST_MUL2;
            end
            gwch_pkg::ST_MUL2:
            begin
                state_next = gwch_pkg::ST_CMP;
            end
            gwch_pkg::ST_CMP:
            begin
                if (more_points)
                begin
                    state_next = gwch_pkg::ST_MUL1;
                end
                else
                begin
                    state_next = gwch_pkg::ST_EMIT;
                end
            end
            gwch_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (cand_is_start || (round_reg == ROUNDS_MAX))
                    begin
                        state_next = gwch_pkg::ST_CLOSE;
                    end
                    else
                    begin
                        state_next = gwch_pkg::ST_ROUND_RD;
                    end
                end
            end
            gwch_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    state_next = gwch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gwch_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        j_next         = j_reg;
        round_next     = round_reg;
        closed_next    = closed_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        cand_next      = cand_reg;
        out_pt_next    = out_pt_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        store_we       = 1'b0;
        alu_ctrl       = '0;
        rd_addr        = j_reg[IDX_W-1:0];

        case (state_reg)
            gwch_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            gwch_pkg::ST_START_RD:
            begin
                rd_addr = '0;
                j_next  = '0;
            end
            gwch_pkg::ST_START_SCAN:
            begin
                // keep the first point of least x
                if (take_start)
                begin
                    start_next = rd_pt;
                    cur_next   = rd_pt;
                end
                else
                begin
                    cur_next = start_reg;
                end
                round_next = '0;
                if (more_points)
                begin
                    j_next  = j_inc;
                    rd_addr = j_inc[IDX_W-1:0];
                end
            end
            gwch_pkg::ST_ROUND_RD:
            begin
                rd_addr    = '0;
                j_next     = '0;
                round_next = round_reg + RND_W'(1);
            end
            gwch_pkg::ST_CAND0:
            begin
                cand_next = rd_pt;
                j_next    = CNT_W'(1);
                rd_addr   = IDX_W'(1);
            end
            gwch_pkg::ST_MUL1:
            begin
                alu_ctrl.load_a = 1'b1;
            end
            gwch_pkg::ST_MUL2:
            begin
                alu_ctrl.load_b = 1'b1;
            end
            gwch_pkg::ST_CMP:
            begin
                if (alu_stat.cand_is_cur || alu_stat.left)
                begin
                    cand_next = rd_pt;
                end
                if (more_points)
                begin
                    j_next  = j_inc;
                    rd_addr = j_inc[IDX_W-1:0];
                end
            end
            gwch_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pt_next    = cur_reg;
                    out_last_next  = 1'b0;
                    out_user_next  = dropped_reg;
                    cur_next       = cand_reg;
                    closed_next    = cand_is_start;
                end
            end
            gwch_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pt_next    = start_reg;
                    out_last_next  = 1'b1;
                    out_user_next  = dropped_reg || !closed_reg;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwch_pkg::ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            j_reg         <= '0;
            round_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            j_reg         <= j_next;
            round_reg     <= round_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        cur_reg      <= cur_next;
        cand_reg     <= cand_next;
        out_pt_reg   <= out_pt_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pt_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule
